// ===== design/rblw_pkg.sv =====
// ----------------------------------------------------------------------------
// rblw_pkg: shared types and constants
// Request kinds, queue entry layout, step codes and panel limits of the
// RGB565 bitmap LCD byte writer.
// ----------------------------------------------------------------------------
package rblw_pkg;

  localparam logic [11:0] PANEL_WIDTH  = 12'd320;
  localparam logic [11:0] PANEL_HEIGHT = 12'd480;

  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;

  localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
  localparam logic [1:0] REG_WIN_TOP    = 2'd1;
  localparam logic [1:0] REG_WIN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_WIN_HEIGHT = 2'd3;

  localparam logic [3:0] STEP_COL_CMD = 4'd0;
  localparam logic [3:0] STEP_C0_HI   = 4'd1;
  localparam logic [3:0] STEP_C0_LO   = 4'd2;
  localparam logic [3:0] STEP_C1_HI   = 4'd3;
  localparam logic [3:0] STEP_C1_LO   = 4'd4;
  localparam logic [3:0] STEP_ROW_CMD = 4'd5;
  localparam logic [3:0] STEP_R0_HI   = 4'd6;
  localparam logic [3:0] STEP_R0_LO   = 4'd7;
  localparam logic [3:0] STEP_R1_HI   = 4'd8;
  localparam logic [3:0] STEP_R1_LO   = 4'd9;
  localparam logic [3:0] STEP_WR_CMD  = 4'd10;
  localparam logic [3:0] STEP_RED     = 4'd11;
  localparam logic [3:0] STEP_GREEN   = 4'd12;
  localparam logic [3:0] STEP_BLUE    = 4'd13;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef enum logic [1:0] {
    KIND_ERR = 2'd0,
    KIND_HDR = 2'd1,
    KIND_PIX = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pixel;
    logic [9:0]  c0;
    logic [10:0] c1;
    logic [10:0] rw;
    logic        last_img;
  } entry_t;

endpackage

// ===== design/rblw_front.sv =====
// ----------------------------------------------------------------------------
// rblw_front: pixel intake and classification
// Holds the window registers and image counters, classifies each pixel
// request and computes its row header values.
// ----------------------------------------------------------------------------
module rblw_front import rblw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pixel,
  output logic        push,
  input  logic        push_ready,
  output entry_t      push_entry
);

  logic [9:0]  win_left_r, win_left_nxt;
  logic [9:0]  win_top_r, win_top_nxt;
  logic [10:0] win_width_r, win_width_nxt;
  logic [10:0] win_height_r, win_height_nxt;
  logic [9:0]  col_r, col_nxt;
  logic [9:0]  row_r, row_nxt;

  logic        win_ok;
  logic        last_col;
  logic        last_row;
  logic [11:0] right_edge;
  logic [11:0] bottom_edge;

  assign in_ready    = push_ready;
  assign push        = in_valid && push_ready;
  assign right_edge  = {2'b00, win_left_r} + {1'b0, win_width_r};
  assign bottom_edge = {2'b00, win_top_r} + {1'b0, win_height_r};
  assign win_ok      = (win_width_r != 11'd0) && (win_height_r != 11'd0) &&
                       (right_edge <= PANEL_WIDTH) && (bottom_edge <= PANEL_HEIGHT);
  assign last_col    = ({1'b0, col_r} + 11'd1) >= win_width_r;
  assign last_row    = ({1'b0, row_r} + 11'd1) >= win_height_r;

  always_comb begin
    push_entry.pixel    = in_pixel;
    push_entry.c0       = win_left_r;
    push_entry.c1       = right_edge[10:0] - 11'd1;
    push_entry.rw       = {1'b0, win_top_r} + {1'b0, row_r};
    push_entry.last_img = last_col && last_row;
    if (!win_ok) begin
      push_entry.kind = KIND_ERR;
    end else if (col_r == 10'd0) begin
      push_entry.kind = KIND_HDR;
    end else begin
      push_entry.kind = KIND_PIX;
    end
  end

  always_comb begin
    win_left_nxt   = win_left_r;
    win_top_nxt    = win_top_r;
    win_width_nxt  = win_width_r;
    win_height_nxt = win_height_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_LEFT:   win_left_nxt   = cfg_wdata[9:0];
        REG_WIN_TOP:    win_top_nxt    = cfg_wdata[9:0];
        REG_WIN_WIDTH:  win_width_nxt  = cfg_wdata;
        REG_WIN_HEIGHT: win_height_nxt = cfg_wdata;
        default: ;
      endcase
      col_nxt = 10'd0;
      row_nxt = 10'd0;
    end else if (push && win_ok) begin
      if (last_col) begin
        col_nxt = 10'd0;
        row_nxt = last_row ? 10'd0 : row_r + 10'd1;
      end else begin
        col_nxt = col_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= 10'd0;
      win_top_r    <= 10'd0;
      win_width_r  <= 11'd320;
      win_height_r <= 11'd480;
      col_r        <= 10'd0;
      row_r        <= 10'd0;
    end else begin
      win_left_r   <= win_left_nxt;
      win_top_r    <= win_top_nxt;
      win_width_r  <= win_width_nxt;
      win_height_r <= win_height_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

endmodule

// ===== design/rblw_queue.sv =====
// ----------------------------------------------------------------------------
// rblw_queue: request queue
// Two-entry queue between the intake and the byte sequencer.
// ----------------------------------------------------------------------------
module rblw_queue import rblw_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   q_valid,
  input  logic   pop,
  output entry_t q_head
);

  entry_t mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign push_ready = count_r != QDEPTH[QAW:0];
  assign q_valid    = count_r != '0;
  assign q_head     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH[QAW:0])
    else $error("queue count beyond depth");

endmodule

// ===== design/rblw_back.sv =====
// ----------------------------------------------------------------------------
// rblw_back: byte sequencer
// Walks each queued request through its header and pixel bytes and drives
// the registered byte output.
// ----------------------------------------------------------------------------
module rblw_back import rblw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  entry_t      q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last_of_run,
  output logic        out_image_done,
  output logic        out_status
);

  logic       busy_r, busy_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       is_data_r;
  logic       last_r;
  logic       done_r;
  logic       status_r;

  logic       advance;
  logic       is_err;
  logic       at_end;
  logic [3:0] idx;
  logic [7:0] byte_sel;
  logic       data_sel;
  logic [4:0] red5;
  logic [4:0] blue5;

  assign is_err  = q_head.kind == KIND_ERR;
  assign advance = q_valid && (!out_valid_r || out_ready);
  assign red5    = q_head.pixel[15:11];
  assign blue5   = q_head.pixel[4:0];

  always_comb begin
    if (busy_r) begin
      idx = step_r;
    end else begin
      unique case (q_head.kind)
        KIND_HDR: idx = STEP_COL_CMD;
        KIND_PIX: idx = STEP_RED;
        default:  idx = STEP_BLUE;
      endcase
    end
  end

  assign at_end = idx == STEP_BLUE;
  assign pop    = advance && at_end;

  always_comb begin
    data_sel = 1'b1;
    unique case (idx)
      STEP_COL_CMD: begin
        byte_sel = CMD_COLUMN;
        data_sel = 1'b0;
      end
      STEP_C0_HI:   byte_sel = {6'd0, q_head.c0[9:8]};
      STEP_C0_LO:   byte_sel = q_head.c0[7:0];
      STEP_C1_HI:   byte_sel = {5'd0, q_head.c1[10:8]};
      STEP_C1_LO:   byte_sel = q_head.c1[7:0];
      STEP_ROW_CMD: begin
        byte_sel = CMD_ROW;
        data_sel = 1'b0;
      end
      STEP_R0_HI:   byte_sel = {5'd0, q_head.rw[10:8]};
      STEP_R0_LO:   byte_sel = q_head.rw[7:0];
      STEP_R1_HI:   byte_sel = {5'd0, q_head.rw[10:8]};
      STEP_R1_LO:   byte_sel = q_head.rw[7:0];
      STEP_WR_CMD:  begin
        byte_sel = CMD_WRITE;
        data_sel = 1'b0;
      end
      STEP_RED:     byte_sel = {red5, red5[4], 2'b00};
      STEP_GREEN:   byte_sel = {q_head.pixel[10:5], 2'b00};
      STEP_BLUE:    byte_sel = {blue5, blue5[4], 2'b00};
      default:      byte_sel = 8'd0;
    endcase
    if (is_err) begin
      byte_sel = 8'd0;
      data_sel = 1'b0;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      busy_nxt      = !at_end;
      step_nxt      = idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r    <= byte_sel;
      is_data_r <= data_sel;
      last_r    <= at_end;
      done_r    <= at_end && q_head.last_img && !is_err;
      status_r  <= is_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_is_data     = is_data_r;
  assign out_last_of_run = last_r;
  assign out_image_done  = done_r;
  assign out_status      = status_r;

  a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> q_valid)
    else $error("sequencer lost its request mid-run");

endmodule

// ===== design/rgb565_bitmap_lcd_byte_writer_core.sv =====
// ----------------------------------------------------------------------------
// rgb565_bitmap_lcd_byte_writer_core: RGB565 bitmap to panel byte stream
// Turns row-major RGB565 pixels into tagged command and RGB666 data bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one RGB565 pixel per request, valid/ready.
//   out_* : one panel byte per request, valid/ready, tagged with is_data,
//           last_of_run, image_done and status.
//   cfg_* : write-only window registers (left, top, width, height); any
//           write restarts the image at its first pixel.
// Each pixel gives three data bytes; the first pixel of a row is preceded
// by an eleven-byte column/row/write header. An invalid window gives one
// status byte per pixel. The byte sequencer emits one byte per cycle while
// the queue holds a request and the receiver is not stalling the output.
// The first byte of a pixel is registered in the queue and then in the
// output register before out_valid rises.
// A two-entry queue sits between intake and sequencer; intake keeps taking
// pixels while the queue has room, and a stalled receiver holds the output
// register, then the sequencer, then the queue, then in_ready.
// Reset empties the queue, clears the counters and loads a 320x480 window
// at the origin.
// ----------------------------------------------------------------------------
module rgb565_bitmap_lcd_byte_writer_core import rblw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last_of_run,
  output logic        out_image_done,
  output logic        out_status
);

  logic   push;
  logic   push_ready;
  entry_t push_entry;
  logic   q_valid;
  logic   pop;
  entry_t q_head;

  rblw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  rblw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .q_valid    (q_valid),
    .pop        (pop),
    .q_head     (q_head)
  );

  rblw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_data     (out_is_data),
    .out_last_of_run (out_last_of_run),
    .out_image_done  (out_image_done),
    .out_status      (out_status)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_last_of_run && !out_status)
    else $error("image end flagged off a pixel's last byte");

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last_of_run && !out_is_data && out_byte == 8'd0)
    else $error("malformed status byte");

endmodule
